// ===== src/partition_fit_allocator_unit_macros.svh =====
// assertion macros for the partition fit allocator
// used by modules that check their own control logic; no other dependencies
`ifndef PARTITION_FIT_ALLOCATOR_UNIT_MACROS_SVH
`define PARTITION_FIT_ALLOCATOR_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication, disabled during reset
`define PFA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("pfa assertion failed");
// next-cycle implication, disabled during reset
`define PFA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("pfa assertion failed");
`else
`define PFA_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define PFA_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== src/pfa_pkg.sv =====
// shared types and constants of the partition fit allocator
// no dependencies
`timescale 1ns / 1ps

package pfa_pkg;

    // fixed widths of the word fields
    localparam int FIELD_W = 16;
    localparam int IDX_W   = 4;
    localparam int CNT_W   = 5;
    localparam int APB_AW  = 4;

    // register index, taken from paddr[3:2]
    localparam logic [1:0] REG_POLICY   = 2'd0;
    localparam logic [1:0] REG_MIN_FRAG = 2'd1;
    localparam logic [1:0] REG_PART_CNT = 2'd2;

    localparam logic [CNT_W-1:0] PART_CNT_RST = 5'd16;

    typedef enum logic [1:0] {
        POL_FIRST = 2'd0,
        POL_NEXT  = 2'd1,
        POL_BEST  = 2'd2,
        POL_WORST = 2'd3
    } t_policy;

    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_ALLOC = 1'b1
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'd0,
        ST_SCAN  = 3'd1,
        ST_DRAIN = 3'd2,
        ST_WB    = 3'd3,
        ST_RES   = 3'd4
    } t_state;

    // table write enables
    typedef struct packed {
        logic wr_start;
        logic wr_size;
    } t_tbl_wr;

endpackage

// ===== src/pfa_table.sv =====
// partition table: start and size memories, one write and one read port each
// depends on pfa_pkg for the write enable struct
`timescale 1ns / 1ps

module pfa_table #(
    parameter int DEPTH = 16,
    parameter int IW    = 4,
    parameter int SW    = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pfa_pkg::t_tbl_wr    i_wr,
    input  logic [IW-1:0]       i_wr_addr,
    input  logic [SW-1:0]       i_wr_start,
    input  logic [SW-1:0]       i_wr_size,
    input  logic [IW-1:0]       i_rd_addr,
    output logic [SW-1:0]       o_rd_start,
    output logic [SW-1:0]       o_rd_size
);

    logic [SW-1:0]    r_start_mem [DEPTH];
    logic [SW-1:0]    r_size_mem  [DEPTH];
    logic [DEPTH-1:0] r_vld;
    logic [SW-1:0]    r_rd_start;
    logic [SW-1:0]    r_rd_size;
    logic             r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr.wr_start) begin
            r_start_mem[i_wr_addr] <= i_wr_start;
        end
        if (i_wr.wr_size) begin
            r_size_mem[i_wr_addr] <= i_wr_size;
        end
        r_rd_start <= r_start_mem[i_rd_addr];
        r_rd_size  <= r_size_mem[i_rd_addr];
    end

    // size entries never written read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr.wr_size) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            r_rd_vld <= r_vld[i_rd_addr];
        end
    end

    assign o_rd_start = r_rd_start;
    assign o_rd_size  = r_rd_vld ? r_rd_size : '0;

endmodule

// ===== src/pfa_ctrl.sv =====
// allocation sequencer: scans the table one entry a cycle, picks, writes back
// depends on pfa_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "partition_fit_allocator_unit_macros.svh"

module pfa_ctrl #(
    parameter int MAX = 16,
    parameter int IW  = 4,
    parameter int CW  = 5,
    parameter int SW  = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pfa_pkg::t_policy              i_policy,
    input  logic [pfa_pkg::FIELD_W-1:0]   i_min_frag,
    input  logic [pfa_pkg::CNT_W-1:0]     i_part_cnt,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_command,
    input  logic [pfa_pkg::IDX_W-1:0]     i_entry_index,
    input  logic [pfa_pkg::FIELD_W-1:0]   i_entry_start,
    input  logic [pfa_pkg::FIELD_W-1:0]   i_entry_size,
    input  logic [pfa_pkg::FIELD_W-1:0]   i_request_size,
    output pfa_pkg::t_tbl_wr              o_wr,
    output logic [IW-1:0]                 o_wr_addr,
    output logic [SW-1:0]                 o_wr_start,
    output logic [SW-1:0]                 o_wr_size,
    output logic [IW-1:0]                 o_rd_addr,
    input  logic [SW-1:0]                 i_rd_start,
    input  logic [SW-1:0]                 i_rd_size,
    output logic                          o_res_valid,
    input  logic                          i_res_take,
    output logic                          o_res_granted,
    output logic [pfa_pkg::IDX_W-1:0]     o_res_index,
    output logic [pfa_pkg::FIELD_W-1:0]   o_res_start,
    output logic [pfa_pkg::FIELD_W-1:0]   o_res_remaining
);

    pfa_pkg::t_state r_state, n_state;
    logic [IW-1:0]   r_k, n_k;
    logic [IW-1:0]   r_j, n_j;
    logic [CW-1:0]   r_n, n_n;
    logic [pfa_pkg::FIELD_W-1:0] r_req, n_req;
    logic [IW-1:0]   r_rot_ptr, n_rot_ptr;
    logic            r_cmp_vld, n_cmp_vld;
    logic [IW-1:0]   r_cmp_idx;
    logic            r_found;
    logic [IW-1:0]   r_best_idx;
    logic [SW-1:0]   r_best_size;
    logic [SW-1:0]   r_best_start;
    logic            r_res_granted, n_res_granted;
    logic [pfa_pkg::IDX_W-1:0]   r_res_index, n_res_index;
    logic [pfa_pkg::FIELD_W-1:0] r_res_start, n_res_start;
    logic [pfa_pkg::FIELD_W-1:0] r_res_rem, n_res_rem;
    logic            n_clear_best;

    logic                        w_accept;
    logic [CW-1:0]               w_used_n;
    logic [IW-1:0]               w_start_p;
    logic [CW-1:0]               w_j_inc;
    logic [IW-1:0]               w_j_next;
    logic                        w_last;
    logic                        w_load_ok;
    logic [pfa_pkg::FIELD_W-1:0] w_size16;
    logic [pfa_pkg::FIELD_W-1:0] w_best16;
    logic                        w_fits;
    logic                        w_take;
    logic                        w_ok;
    logic [pfa_pkg::FIELD_W-1:0] w_diff;
    logic [pfa_pkg::FIELD_W-1:0] w_rem;
    logic [CW-1:0]               w_ptr_inc;
    logic [IW-1:0]               w_ptr_next;

    assign w_accept = i_in_valid && (r_state == pfa_pkg::ST_IDLE);

    // entries in use, saturated to the table depth
    assign w_used_n  = (32'(i_part_cnt) > 32'(MAX)) ? CW'(MAX) : CW'(i_part_cnt);
    assign w_start_p = (CW'(r_rot_ptr) < w_used_n) ? r_rot_ptr : '0;
    assign w_j_inc   = CW'(r_j) + CW'(1);
    assign w_j_next  = (w_j_inc == r_n) ? '0 : IW'(w_j_inc);
    assign w_last    = (CW'(r_k) == (r_n - CW'(1)));
    assign w_load_ok = 32'(i_entry_index) < 32'(MAX);

    // compare stage, one entry behind the read address
    assign w_size16 = pfa_pkg::FIELD_W'(i_rd_size);
    assign w_best16 = pfa_pkg::FIELD_W'(r_best_size);
    assign w_fits   = (w_size16 >= r_req);

    always_comb begin
        unique case (i_policy)
            pfa_pkg::POL_FIRST,
            pfa_pkg::POL_NEXT:  w_take = w_fits && !r_found;
            pfa_pkg::POL_BEST:  w_take = w_fits && (!r_found || (w_size16 < w_best16));
            pfa_pkg::POL_WORST: w_take = !r_found || (w_size16 > w_best16);
        endcase
    end

    // worst fit keeps the largest entry and checks fit only at the end
    assign w_ok   = r_found && (w_best16 >= r_req);
    assign w_diff = w_best16 - r_req;
    assign w_rem  = (((i_policy == pfa_pkg::POL_FIRST) || (i_policy == pfa_pkg::POL_NEXT))
                     && (w_diff <= i_min_frag)) ? '0 : w_diff;
    assign w_ptr_inc  = CW'(r_best_idx) + CW'(1);
    assign w_ptr_next = (w_ptr_inc >= r_n) ? '0 : IW'(w_ptr_inc);

    always_comb begin
        n_state       = r_state;
        n_k           = r_k;
        n_j           = r_j;
        n_n           = r_n;
        n_req         = r_req;
        n_rot_ptr     = r_rot_ptr;
        n_cmp_vld     = 1'b0;
        n_clear_best  = 1'b0;
        n_res_granted = r_res_granted;
        n_res_index   = r_res_index;
        n_res_start   = r_res_start;
        n_res_rem     = r_res_rem;
        o_wr          = '0;
        o_wr_addr     = r_best_idx;
        o_wr_start    = SW'(i_entry_start);
        o_wr_size     = SW'(w_rem);
        unique case (r_state)
            pfa_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_res_granted = 1'b0;
                    n_res_index   = '0;
                    n_res_start   = '0;
                    n_res_rem     = '0;
                    if (pfa_pkg::t_cmd'(i_command) == pfa_pkg::CMD_LOAD) begin
                        o_wr.wr_start = w_load_ok;
                        o_wr.wr_size  = w_load_ok;
                        o_wr_addr     = IW'(i_entry_index);
                        o_wr_size     = SW'(i_entry_size);
                        n_state       = pfa_pkg::ST_RES;
                    end else begin
                        n_req        = i_request_size;
                        n_n          = w_used_n;
                        n_k          = '0;
                        // only next fit starts at the pointer, the others at entry 0
                        n_j          = (i_policy == pfa_pkg::POL_NEXT) ? w_start_p : '0;
                        n_clear_best = 1'b1;
                        n_state      = (w_used_n == '0) ? pfa_pkg::ST_RES : pfa_pkg::ST_SCAN;
                    end
                end
            end
            pfa_pkg::ST_SCAN: begin
                n_cmp_vld = 1'b1;
                n_k       = r_k + IW'(1);
                n_j       = w_j_next;
                if (w_last) begin
                    n_state = pfa_pkg::ST_DRAIN;
                end
            end
            pfa_pkg::ST_DRAIN: begin
                n_state = pfa_pkg::ST_WB;
            end
            pfa_pkg::ST_WB: begin
                if (w_ok) begin
                    o_wr.wr_size  = 1'b1;
                    n_res_granted = 1'b1;
                    n_res_index   = pfa_pkg::IDX_W'(r_best_idx);
                    n_res_start   = pfa_pkg::FIELD_W'(r_best_start);
                    n_res_rem     = w_rem;
                    if (i_policy == pfa_pkg::POL_NEXT) begin
                        n_rot_ptr = w_ptr_next;
                    end
                end
                n_state = pfa_pkg::ST_RES;
            end
            pfa_pkg::ST_RES: begin
                if (i_res_take) begin
                    n_state = pfa_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = pfa_pkg::ST_IDLE;
            end
        endcase
    end

    // the scan reads only while no write is issued, so no forwarding is needed
    assign o_rd_addr = r_j;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= pfa_pkg::ST_IDLE;
            r_rot_ptr <= '0;
            r_cmp_vld <= 1'b0;
            r_found   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rot_ptr <= n_rot_ptr;
            r_cmp_vld <= n_cmp_vld;
            if (n_clear_best) begin
                r_found <= 1'b0;
            end else if (r_cmp_vld && w_take) begin
                r_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_k           <= n_k;
        r_j           <= n_j;
        r_n           <= n_n;
        r_req         <= n_req;
        r_cmp_idx     <= r_j;
        r_res_granted <= n_res_granted;
        r_res_index   <= n_res_index;
        r_res_start   <= n_res_start;
        r_res_rem     <= n_res_rem;
        if (r_cmp_vld && w_take) begin
            r_best_idx   <= r_cmp_idx;
            r_best_size  <= i_rd_size;
            r_best_start <= i_rd_start;
        end
    end

    assign o_in_stall      = (r_state != pfa_pkg::ST_IDLE);
    assign o_res_valid     = (r_state == pfa_pkg::ST_RES);
    assign o_res_granted   = r_res_granted;
    assign o_res_index     = r_res_index;
    assign o_res_start     = r_res_start;
    assign o_res_remaining = r_res_rem;

    `PFA_ASSERT_IMP(a_scan_in_range, i_clk, i_rst_n, r_state == pfa_pkg::ST_SCAN, CW'(r_j) < r_n)
    `PFA_ASSERT_NXT(a_alloc_busy, i_clk, i_rst_n, w_accept && (i_command == pfa_pkg::CMD_ALLOC), (r_state == pfa_pkg::ST_SCAN) || (r_state == pfa_pkg::ST_RES))
    `PFA_ASSERT_IMP(a_drain_after_scan, i_clk, i_rst_n, r_state == pfa_pkg::ST_DRAIN, $past(r_state) == pfa_pkg::ST_SCAN)
    `PFA_ASSERT_IMP(a_grant_has_pick, i_clk, i_rst_n, (r_state == pfa_pkg::ST_RES) && r_res_granted, r_found)

endmodule

// ===== src/partition_fit_allocator_unit.sv =====
// a load writes the table on accept, then sends its word via the result state to the output
// register; an allocate scans the n entries in use, drains, writes back and sends its word
// on the same way (n = 0 goes straight to the result state and fails); a new input word is
// taken once the last has moved out; the size memory read port steps through one entry a
// cycle during the scan; reset (synchronous, active low) zeroes all sizes via per-entry
// valid bits, next-fit pointer, policy and min-frag, sets part count to 16; starts unknown till loaded
`timescale 1ns / 1ps

module partition_fit_allocator_unit #(
    parameter int MAX_PARTITIONS = 16,
    parameter int ADDR_BITS      = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // apb config port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [pfa_pkg::APB_AW-1:0]        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    // input words
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_command,
    input  logic [pfa_pkg::IDX_W-1:0]         i_entry_index,
    input  logic [pfa_pkg::FIELD_W-1:0]       i_entry_start,
    input  logic [pfa_pkg::FIELD_W-1:0]       i_entry_size,
    input  logic [pfa_pkg::FIELD_W-1:0]       i_request_size,
    // result words
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_granted,
    output logic [pfa_pkg::IDX_W-1:0]         o_chosen_index,
    output logic [pfa_pkg::FIELD_W-1:0]       o_chosen_start,
    output logic [pfa_pkg::FIELD_W-1:0]       o_remaining_size
);

    // table index, count and stored value widths
    localparam int IW = $clog2(MAX_PARTITIONS);
    localparam int CW = $clog2(MAX_PARTITIONS + 1);
    localparam int SW = (ADDR_BITS < pfa_pkg::FIELD_W) ? ADDR_BITS : pfa_pkg::FIELD_W;

    // config registers
    pfa_pkg::t_policy              r_policy;
    logic [pfa_pkg::FIELD_W-1:0]   r_min_frag;
    logic [pfa_pkg::CNT_W-1:0]     r_part_cnt;
    logic [1:0]                    w_reg_idx;
    logic                          w_cfg_wr;

    // table port between sequencer and memories
    pfa_pkg::t_tbl_wr              w_wr;
    logic [IW-1:0]                 w_wr_addr;
    logic [SW-1:0]                 w_wr_start;
    logic [SW-1:0]                 w_wr_size;
    logic [IW-1:0]                 w_rd_addr;
    logic [SW-1:0]                 w_rd_start;
    logic [SW-1:0]                 w_rd_size;

    // finished word from the sequencer
    logic                          w_res_valid;
    logic                          w_res_take;
    logic                          w_res_granted;
    logic [pfa_pkg::IDX_W-1:0]     w_res_index;
    logic [pfa_pkg::FIELD_W-1:0]   w_res_start;
    logic [pfa_pkg::FIELD_W-1:0]   w_res_remaining;

    // output register
    logic                          r_out_valid;
    logic                          r_out_granted;
    logic [pfa_pkg::IDX_W-1:0]     r_out_index;
    logic [pfa_pkg::FIELD_W-1:0]   r_out_start;
    logic [pfa_pkg::FIELD_W-1:0]   r_out_remaining;

    // apb: word-aligned registers, low address bits ignored, no wait states
    assign pready    = 1'b1;
    assign w_reg_idx = paddr[3:2];
    assign w_cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy   <= pfa_pkg::POL_FIRST;
            r_min_frag <= '0;
            r_part_cnt <= pfa_pkg::PART_CNT_RST;
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                pfa_pkg::REG_POLICY:   r_policy   <= pfa_pkg::t_policy'(pwdata[1:0]);
                pfa_pkg::REG_MIN_FRAG: r_min_frag <= pwdata[pfa_pkg::FIELD_W-1:0];
                pfa_pkg::REG_PART_CNT: r_part_cnt <= pwdata[pfa_pkg::CNT_W-1:0];
                default: begin
                    // unmapped register, write dropped
                end
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            pfa_pkg::REG_POLICY:   prdata = 32'(r_policy);
            pfa_pkg::REG_MIN_FRAG: prdata = 32'(r_min_frag);
            pfa_pkg::REG_PART_CNT: prdata = 32'(r_part_cnt);
            default:               prdata = '0;
        endcase
    end

    // start and size memories
    pfa_table #(
        .DEPTH (MAX_PARTITIONS),
        .IW    (IW),
        .SW    (SW)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (w_wr),
        .i_wr_addr  (w_wr_addr),
        .i_wr_start (w_wr_start),
        .i_wr_size  (w_wr_size),
        .i_rd_addr  (w_rd_addr),
        .o_rd_start (w_rd_start),
        .o_rd_size  (w_rd_size)
    );

    // scan, pick and write-back sequencer
    pfa_ctrl #(
        .MAX (MAX_PARTITIONS),
        .IW  (IW),
        .CW  (CW),
        .SW  (SW)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_policy        (r_policy),
        .i_min_frag      (r_min_frag),
        .i_part_cnt      (r_part_cnt),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_command       (i_command),
        .i_entry_index   (i_entry_index),
        .i_entry_start   (i_entry_start),
        .i_entry_size    (i_entry_size),
        .i_request_size  (i_request_size),
        .o_wr            (w_wr),
        .o_wr_addr       (w_wr_addr),
        .o_wr_start      (w_wr_start),
        .o_wr_size       (w_wr_size),
        .o_rd_addr       (w_rd_addr),
        .i_rd_start      (w_rd_start),
        .i_rd_size       (w_rd_size),
        .o_res_valid     (w_res_valid),
        .i_res_take      (w_res_take),
        .o_res_granted   (w_res_granted),
        .o_res_index     (w_res_index),
        .o_res_start     (w_res_start),
        .o_res_remaining (w_res_remaining)
    );

    // output register: frees the sequencer as soon as the word moves out,
    // so the next input word can be taken while this one waits downstream
    assign w_res_take = w_res_valid && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_take) begin
            r_out_granted   <= w_res_granted;
            r_out_index     <= w_res_index;
            r_out_start     <= w_res_start;
            r_out_remaining <= w_res_remaining;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_granted        = r_out_granted;
    assign o_chosen_index   = r_out_index;
    assign o_chosen_start   = r_out_start;
    assign o_remaining_size = r_out_remaining;

endmodule
